// ===== hw/rtl/tap_dance_key_sequencer_core_assert.svh =====
// Assertion macros for the tap-dance key sequencer core.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef TAP_DANCE_KEY_SEQUENCER_CORE_ASSERT_SVH
`define TAP_DANCE_KEY_SEQUENCER_CORE_ASSERT_SVH

// Implication that must hold at every edge out of reset.
`define TDK_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must hold in the same cycle whenever the guard holds.
`define TDK_ASSERT_WHEN(lbl, guard, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (guard) |-> (cond)) else $error(msg);

`endif

// ===== hw/rtl/tdk_pkg.sv =====
// Types and constants for the tap-dance key sequencer.
// No dependencies.
`default_nettype none
package tdk_pkg;

   localparam logic [15:0] TIMEOUT_RESET = 16'd200;
   localparam logic [7:0]  TAPS_MAX      = 8'd255;

   localparam logic [1:0] KIND_PASS   = 2'd0;
   localparam logic [1:0] KIND_REPLAY = 2'd1;
   localparam logic [1:0] KIND_ACTION = 2'd2;

   localparam logic [1:0] ACT_TAP       = 2'd0;
   localparam logic [1:0] ACT_INTERRUPT = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT   = 2'd2;
   localparam logic [1:0] ACT_HOLD      = 2'd3;

   typedef struct packed {
      logic [7:0]  addr;
      logic        pressed;
      logic [15:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PRE,
      S_FLUSH,
      S_POST
   } state_type;

   typedef enum logic [1:0] {
      POST_NONE,
      POST_PASS,
      POST_TAP
   } post_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tap_dance_key_sequencer_core.sv =====
// Tap-dance key sequencer: one item at a time, request captured then decoded.
// The request is captured, then decoded; results leave through the output register, one per cycle while not stalled.
// The flush walk reads one queue memory entry per cycle unless a replayed entry meets a stalled output;
// a new request is taken only once the item is done and the core is back in idle.
// Reset (synchronous, active high) empties the queue, clears taps and index, timeout 200.
// Depends on tdk_pkg, tdk_ram and tap_dance_key_sequencer_core_assert.svh.
`default_nettype none
module tap_dance_key_sequencer_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_key_addr,
   input  wire logic        req_pressed,
   input  wire logic        req_injected,
   input  wire logic        req_is_tapdance,
   input  wire logic [7:0]  req_td_index,
   input  wire logic [15:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_addr,
   output logic             rsp_out_pressed,
   output logic [15:0]      rsp_out_time,
   output logic [1:0]       rsp_action,
   output logic [7:0]       rsp_action_index,
   output logic [7:0]       rsp_tap_count,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import tdk_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int EW = $bits(entry_type);

   // control state
   state_type   state_ff, state_in;
   logic [QW-1:0] qlen_ff, qlen_in;
   logic [QW-1:0] idx_ff, idx_in;
   logic [7:0]  taps_ff, taps_in;
   logic [7:0]  seq_idx_ff, seq_idx_in;
   logic [15:0] timeout_ff;
   logic        rel_seen_ff, rel_seen_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // plan for the item in flight
   logic        pre_ff, pre_in;
   logic [1:0]  pre_code_ff, pre_code_in;
   logic        skip_ff, skip_in;
   logic        clr_ff, clr_in;
   logic        newseq_ff, newseq_in;
   post_type    post_ff, post_in;

   // captured item and sequence head
   logic        evt_kind_ff, evt_pressed_ff, evt_injected_ff, evt_is_td_ff;
   logic [7:0]  evt_addr_ff, evt_td_ff;
   logic [15:0] evt_now_ff;
   logic [7:0]  head_addr_ff, head_addr_in;
   logic [15:0] head_time_ff, head_time_in;

   // output register payload
   logic [1:0]  o_kind_ff, o_kind_in;
   logic [7:0]  o_addr_ff, o_addr_in;
   logic        o_pressed_ff, o_pressed_in;
   logic [15:0] o_time_ff, o_time_in;
   logic [1:0]  o_act_ff, o_act_in;
   logic [7:0]  o_idx_ff, o_idx_in;
   logic [7:0]  o_cnt_ff, o_cnt_in;
   logic        o_last_ff, o_last_in;
   logic        load;

   // queue memory
   logic          ram_we;
   logic [IW-1:0] ram_wa;
   entry_type     ram_wd;
   logic [EW-1:0] ram_rd;
   entry_type     ent;

   logic        accept, out_free, skip_hit, consume, flush_end;
   logic [15:0] elapsed;
   logic [7:0]  taps_sat;

   tdk_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (idx_in[IW-1:0]),
      .rd_data (ram_rd)
   );

   assign ent       = entry_type'(ram_rd);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign elapsed   = evt_now_ff - head_time_ff;
   assign taps_sat  = (taps_ff == TAPS_MAX) ? taps_ff : taps_ff + 8'd1;
   assign skip_hit  = skip_ff && (ent.addr == evt_addr_ff);
   assign consume   = skip_hit || out_free;
   assign flush_end = (QW'(idx_ff + QW'(1)) == qlen_ff);

   always_comb begin
      state_in     = state_ff;
      qlen_in      = qlen_ff;
      idx_in       = '0;
      taps_in      = taps_ff;
      seq_idx_in   = seq_idx_ff;
      rel_seen_in  = rel_seen_ff;
      pre_in       = pre_ff;
      pre_code_in  = pre_code_ff;
      skip_in      = skip_ff;
      clr_in       = clr_ff;
      newseq_in    = newseq_ff;
      post_in      = post_ff;
      head_addr_in = head_addr_ff;
      head_time_in = head_time_ff;
      ram_we       = 1'b0;
      ram_wa       = qlen_ff[IW-1:0];
      ram_wd       = '{addr: evt_addr_ff, pressed: evt_pressed_ff, stamp: evt_now_ff};
      load         = 1'b0;
      o_kind_in    = KIND_PASS;
      o_addr_in    = evt_addr_ff;
      o_pressed_in = evt_pressed_ff;
      o_time_in    = '0;
      o_act_in     = ACT_TAP;
      o_idx_in     = '0;
      o_cnt_in     = '0;
      o_last_in    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pre_in      = 1'b0;
            pre_code_in = ACT_TAP;
            skip_in     = 1'b0;
            clr_in      = 1'b0;
            newseq_in   = 1'b0;
            post_in     = POST_NONE;
            if (evt_kind_ff) begin
               // tick: fire hold or timeout once the head entry is old enough
               if (qlen_ff != '0 && elapsed > timeout_ff) begin
                  pre_in      = 1'b1;
                  pre_code_in = rel_seen_ff ? ACT_TIMEOUT : ACT_HOLD;
                  clr_in      = 1'b1;
               end
            end else if (evt_injected_ff) begin
               post_in = POST_PASS;
            end else if (!evt_pressed_ff) begin
               if (qlen_ff == '0 || qlen_ff >= QW'(QUEUE_DEPTH)) begin
                  post_in = POST_PASS;
               end else begin
                  // hold the release back in the queue
                  ram_we  = 1'b1;
                  qlen_in = QW'(qlen_ff + QW'(1));
                  if (evt_addr_ff == head_addr_ff) begin
                     rel_seen_in = 1'b1;
                  end
               end
            end else if (qlen_ff == '0 && !evt_is_td_ff) begin
               post_in = POST_PASS;
            end else if (qlen_ff != '0 && evt_addr_ff != head_addr_ff) begin
               // another key interrupts the sequence
               pre_in      = 1'b1;
               pre_code_in = ACT_INTERRUPT;
               clr_in      = 1'b1;
               newseq_in   = 1'b1;
               post_in     = evt_is_td_ff ? POST_TAP : POST_PASS;
            end else begin
               // first or repeated press of the sequence key
               skip_in   = 1'b1;
               newseq_in = (qlen_ff == '0);
               post_in   = POST_TAP;
            end
            if (pre_in) begin
               state_in = S_PRE;
            end else if (post_in == POST_TAP && qlen_ff != '0) begin
               state_in = S_FLUSH;
            end else if (post_in != POST_NONE) begin
               state_in = S_POST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PRE: begin
            o_kind_in    = KIND_ACTION;
            o_addr_in    = head_addr_ff;
            o_pressed_in = 1'b0;
            o_act_in     = pre_code_ff;
            o_idx_in     = seq_idx_ff;
            o_cnt_in     = taps_ff;
            o_last_in    = 1'b0;
            if (out_free) begin
               load     = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // replay one queued entry per cycle, drop those of the sequence key; kept ones wait out a stall
            o_kind_in    = KIND_REPLAY;
            o_addr_in    = ent.addr;
            o_pressed_in = ent.pressed;
            o_time_in    = ent.stamp;
            o_last_in    = flush_end && (post_ff == POST_NONE);
            idx_in       = idx_ff;
            if (consume) begin
               load   = !skip_hit;
               idx_in = QW'(idx_ff + QW'(1));
               if (flush_end) begin
                  idx_in  = '0;
                  qlen_in = '0;
                  if (clr_ff) begin
                     taps_in = '0;
                  end
                  state_in = (post_ff == POST_NONE) ? S_IDLE : S_POST;
               end
            end
         end
         S_POST: begin
            if (post_ff == POST_TAP) begin
               o_kind_in    = KIND_ACTION;
               o_pressed_in = 1'b0;
               o_act_in     = ACT_TAP;
               o_idx_in     = newseq_ff ? evt_td_ff : seq_idx_ff;
               o_cnt_in     = taps_sat;
            end
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               if (post_ff == POST_TAP) begin
                  // open or restart the sequence with this press at the head
                  ram_we       = 1'b1;
                  ram_wa       = '0;
                  qlen_in      = QW'(1);
                  taps_in      = taps_sat;
                  seq_idx_in   = o_idx_in;
                  head_addr_in = evt_addr_ff;
                  head_time_in = evt_now_ff;
                  rel_seen_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qlen_ff      <= '0;
         idx_ff       <= '0;
         taps_ff      <= '0;
         seq_idx_ff   <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rel_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qlen_ff      <= qlen_in;
         idx_ff       <= idx_in;
         taps_ff      <= taps_in;
         seq_idx_ff   <= seq_idx_in;
         rel_seen_ff  <= rel_seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_ff       <= pre_in;
      pre_code_ff  <= pre_code_in;
      skip_ff      <= skip_in;
      clr_ff       <= clr_in;
      newseq_ff    <= newseq_in;
      post_ff      <= post_in;
      head_addr_ff <= head_addr_in;
      head_time_ff <= head_time_in;
      if (accept) begin
         evt_kind_ff     <= req_kind;
         evt_addr_ff     <= req_key_addr;
         evt_pressed_ff  <= req_pressed;
         evt_injected_ff <= req_injected;
         evt_is_td_ff    <= req_is_tapdance;
         evt_td_ff       <= req_td_index;
         evt_now_ff      <= req_now;
      end
      if (load) begin
         o_kind_ff    <= o_kind_in;
         o_addr_ff    <= o_addr_in;
         o_pressed_ff <= o_pressed_in;
         o_time_ff    <= o_time_in;
         o_act_ff     <= o_act_in;
         o_idx_ff     <= o_idx_in;
         o_cnt_ff     <= o_cnt_in;
         o_last_ff    <= o_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = o_kind_ff;
   assign rsp_out_addr     = o_addr_ff;
   assign rsp_out_pressed  = o_pressed_ff;
   assign rsp_out_time     = o_time_ff;
   assign rsp_action       = o_act_ff;
   assign rsp_action_index = o_idx_ff;
   assign rsp_tap_count    = o_cnt_ff;
   assign rsp_last         = o_last_ff;

`include "tap_dance_key_sequencer_core_assert.svh"

   `TDK_ASSERT_ALWAYS(a_qlen_bound, (qlen_ff <= QW'(QUEUE_DEPTH)), "queue length beyond depth")
   `TDK_ASSERT_WHEN(a_flush_nonempty, state_ff == S_FLUSH, idx_ff < qlen_ff, "flush index out of queue")
   `TDK_ASSERT_WHEN(a_taps_live, state_ff == S_IDLE && qlen_ff != '0, taps_ff != '0, "queued sequence with no taps")

endmodule
`default_nettype wire

// ===== hw/rtl/tdk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdk_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
